@@ sv/srsw_pkg.sv @@
// shared constants, register codes and controller/datapath types for the sender window
package srsw_pkg;

   localparam int WINDOW_MAX_DEF = 32;
   localparam int SEQ_BITS_DEF   = 16;
   localparam int TIME_BITS_DEF  = 32;

   localparam int FIELD_W    = 16;
   localparam int WND_REG_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [FIELD_W-1:0]   TOTAL_RESET   = 16'd100;
   localparam logic [WND_REG_W-1:0] WINDOW_RESET  = 6'd4;
   localparam logic [FIELD_W-1:0]   TIMEOUT_RESET = 16'd2000;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   typedef struct packed {
      logic accept;
      logic slide_step;
      logic issue_step;
      logic scan_read;
      logic scan_check;
      logic emit_read;
      logic emit_load;
   } cmd_type;

   typedef struct packed {
      logic slide_go;
      logic base_below_total;
      logic issue_go;
      logic scan_go;
      logic out_free;
      logic emit_last;
   } stat_type;

endpackage

@@ sv/srsw_if.sv @@
// request and response channel interfaces of the sender window
interface srsw_req_if import srsw_pkg::*;;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [FIELD_W-1:0] ack_number;

   modport source (output valid, opcode, ack_number, input ready);
   modport sink   (input valid, opcode, ack_number, output ready);
endinterface

interface srsw_rsp_if import srsw_pkg::*;;
   logic               valid;
   logic               ready;
   logic               send_valid;
   logic [FIELD_W-1:0] send_sequence;
   logic               is_retransmit;
   logic               last;
   logic [FIELD_W-1:0] window_base;
   logic               done_res;
   logic [FIELD_W-1:0] retransmit_total;

   modport source (output valid, send_valid, send_sequence, is_retransmit, last,
                   window_base, done_res, retransmit_total, input ready);
   modport sink   (input valid, send_valid, send_sequence, is_retransmit, last,
                   window_base, done_res, retransmit_total, output ready);
endinterface

@@ sv/srsw_ctrl.sv @@
// sequencing state machine: accept, slide, issue, timeout scan, result drain
module srsw_ctrl import srsw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SLIDE    = 3'd1;
   localparam logic [2:0] ST_ISSUE    = 3'd2;
   localparam logic [2:0] ST_SCAN_RD  = 3'd3;
   localparam logic [2:0] ST_SCAN_CHK = 3'd4;
   localparam logic [2:0] ST_EMIT_RD  = 3'd5;
   localparam logic [2:0] ST_EMIT_LD  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SLIDE;
            end
         end
         ST_SLIDE: begin
            if (stat.slide_go) begin
               cmd.slide_step = 1'b1;
            end else if (stat.base_below_total) begin
               state_in = ST_ISSUE;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_ISSUE: begin
            if (stat.issue_go) begin
               cmd.issue_step = 1'b1;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (stat.scan_go) begin
               cmd.scan_read = 1'b1;
               state_in      = ST_SCAN_CHK;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_SCAN_CHK: begin
            cmd.scan_check = 1'b1;
            state_in       = ST_SCAN_RD;
         end
         ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (stat.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

@@ sv/srsw_dp.sv @@
// window datapath: config registers, sequence pointers, ack flags, send times, result queue
module srsw_dp import srsw_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF,
   parameter int SEQ_BITS   = SEQ_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_opcode,
   input  logic [FIELD_W-1:0]    req_ack_number,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_send_valid,
   output logic [FIELD_W-1:0]    rsp_send_sequence,
   output logic                  rsp_is_retransmit,
   output logic                  rsp_last,
   output logic [FIELD_W-1:0]    rsp_window_base,
   output logic                  rsp_done_res,
   output logic [FIELD_W-1:0]    rsp_retransmit_total
);

   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int W      = ((SEQ_BITS > FIELD_W) ? SEQ_BITS : FIELD_W) + 1;

   localparam logic [W-1:0]        SEQ_MAX   = {{(W-SEQ_BITS){1'b0}}, {SEQ_BITS{1'b1}}};
   localparam logic [W-1:0]        WMAX_W    = W'(WINDOW_MAX);
   localparam logic [W-1:0]        ONE_W     = W'(1);
   localparam logic [CNT_W-1:0]    CNT_MAX   = CNT_W'(WINDOW_MAX);
   localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);
   localparam logic [SLOT_W:0]     SLOT_NUM  = (SLOT_W+1)'(WINDOW_MAX);
   localparam logic [FIELD_W-1:0]  RETX_SAT  = '1;

   typedef struct packed {
      logic               retx;
      logic [FIELD_W-1:0] seq;
   } q_entry_type;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      r = (s == SLOT_LAST) ? '0 : s + 1'b1;
      return r;
   endfunction

   // config
   logic [FIELD_W-1:0]   total_ff,   total_in;
   logic [WND_REG_W-1:0] wnd_ff,     wnd_in;
   logic [FIELD_W-1:0]   timeout_ff, timeout_in;

   // window state
   logic [SEQ_BITS-1:0]   base_ff, base_in;
   logic [SEQ_BITS-1:0]   next_ff, next_in;
   logic [SEQ_BITS-1:0]   ptr_ff,  ptr_in;
   logic [SLOT_W-1:0]     base_slot_ff, base_slot_in;
   logic [SLOT_W-1:0]     next_slot_ff, next_slot_in;
   logic [SLOT_W-1:0]     ptr_slot_ff,  ptr_slot_in;
   logic [WINDOW_MAX-1:0] acked_ff, acked_in;
   logic [TIME_BITS-1:0]  now_ff,  now_in;
   logic [FIELD_W-1:0]    retx_ff, retx_in;
   logic [CNT_W-1:0]      qcnt_ff, qcnt_in;
   logic [CNT_W-1:0]      rd_ff,   rd_in;

   // output word
   logic                out_valid_ff, out_valid_in;
   logic                out_send_ff,  out_send_in;
   logic [FIELD_W-1:0]  out_seq_ff,   out_seq_in;
   logic                out_retx_ff,  out_retx_in;
   logic                out_last_ff,  out_last_in;
   logic [FIELD_W-1:0]  out_base_ff,  out_base_in;
   logic                out_done_ff,  out_done_in;
   logic [FIELD_W-1:0]  out_total_ff, out_total_in;

   // memories
   logic [TIME_BITS-1:0] sent_at_mem [WINDOW_MAX];
   logic [TIME_BITS-1:0] sent_rd_ff;
   q_entry_type          queue_mem [WINDOW_MAX];
   q_entry_type          q_rd_ff;

   logic [W-1:0]         total_w, total_eff, wnd_w, wnd_eff;
   logic [W-1:0]         base_w, next_w, ptr_w, ack_w, ack_diff;
   logic [SLOT_W:0]      ack_sum, ack_wrap;
   logic [SLOT_W-1:0]    ack_slot;
   logic                 ack_hit;
   logic                 flag_rd;
   logic [TIME_BITS-1:0] age;
   logic                 retx_hit;
   logic                 push;
   logic                 mem_we;
   logic [SLOT_W-1:0]    mem_waddr;
   q_entry_type          q_wdata;
   logic                 emit_last;

   always_comb begin
      total_w   = W'(total_ff);
      total_eff = (total_w > SEQ_MAX) ? SEQ_MAX : total_w;
      wnd_w     = W'(wnd_ff);
      if (wnd_w == '0) begin
         wnd_eff = ONE_W;
      end else if (wnd_w > WMAX_W) begin
         wnd_eff = WMAX_W;
      end else begin
         wnd_eff = wnd_w;
      end

      base_w = W'(base_ff);
      next_w = W'(next_ff);
      ptr_w  = W'(ptr_ff);
      ack_w  = W'(req_ack_number);

      // ack lies less than one window past the base, so one wrap at most
      ack_diff = ack_w - base_w;
      ack_sum  = {1'b0, base_slot_ff} + {1'b0, ack_diff[SLOT_W-1:0]};
      ack_wrap = ack_sum - SLOT_NUM;
      ack_slot = (ack_sum >= SLOT_NUM) ? ack_wrap[SLOT_W-1:0] : ack_sum[SLOT_W-1:0];
      ack_hit  = (req_opcode == OP_ACK) && (ack_w >= base_w) && (ack_w < next_w) &&
                 (ack_w < total_eff);

      flag_rd  = acked_ff[ptr_slot_ff];
      age      = now_ff - sent_rd_ff;
      retx_hit = !flag_rd && (age > TIME_BITS'(timeout_ff));
      push     = cmd.issue_step || (cmd.scan_check && retx_hit);
      mem_we   = push;
      mem_waddr = cmd.issue_step ? next_slot_ff : ptr_slot_ff;
      q_wdata.retx = !cmd.issue_step;
      q_wdata.seq  = cmd.issue_step ? FIELD_W'(next_ff) : FIELD_W'(ptr_ff);
      emit_last = (qcnt_ff == '0) || (rd_ff == qcnt_ff);

      stat.slide_go         = (base_w < total_eff) && (base_w < next_w) && flag_rd;
      stat.base_below_total = (base_w < total_eff);
      stat.issue_go         = (next_w < total_eff) && ((next_w - base_w) < wnd_eff) &&
                              (qcnt_ff < CNT_MAX);
      stat.scan_go          = (ptr_w < next_w) && (qcnt_ff < CNT_MAX);
      stat.out_free         = !out_valid_ff || rsp_ready;
      stat.emit_last        = emit_last;
   end

   always_comb begin
      total_in   = total_ff;
      wnd_in     = wnd_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_PACKETS: total_in   = csr_wdata;
            CSR_WINDOW_SIZE:   wnd_in     = csr_wdata[WND_REG_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      base_in      = base_ff;
      next_in      = next_ff;
      ptr_in       = ptr_ff;
      base_slot_in = base_slot_ff;
      next_slot_in = next_slot_ff;
      ptr_slot_in  = ptr_slot_ff;
      acked_in     = acked_ff;
      now_in       = now_ff;
      retx_in      = retx_ff;
      qcnt_in      = qcnt_ff;
      rd_in        = rd_ff;

      if (cmd.accept) begin
         if (req_opcode == OP_TICK) begin
            now_in = now_ff + 1'b1;
         end
         if (ack_hit) begin
            acked_in[ack_slot] = 1'b1;
         end
         ptr_in      = base_ff;
         ptr_slot_in = base_slot_ff;
         qcnt_in     = '0;
         rd_in       = '0;
      end

      if (cmd.slide_step) begin
         acked_in[ptr_slot_ff] = 1'b0;
         base_in      = base_ff + 1'b1;
         base_slot_in = slot_inc(base_slot_ff);
         ptr_in       = ptr_ff + 1'b1;
         ptr_slot_in  = slot_inc(ptr_slot_ff);
      end

      if (cmd.issue_step) begin
         acked_in[next_slot_ff] = 1'b0;
         next_in      = next_ff + 1'b1;
         next_slot_in = slot_inc(next_slot_ff);
      end

      if (cmd.scan_check) begin
         ptr_in      = ptr_ff + 1'b1;
         ptr_slot_in = slot_inc(ptr_slot_ff);
         if (retx_hit && (retx_ff != RETX_SAT)) begin
            retx_in = retx_ff + 1'b1;
         end
      end

      if (push) begin
         qcnt_in = qcnt_ff + 1'b1;
      end

      if (cmd.emit_read) begin
         rd_in = rd_ff + 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_send_in  = out_send_ff;
      out_seq_in   = out_seq_ff;
      out_retx_in  = out_retx_ff;
      out_last_in  = out_last_ff;
      out_base_in  = out_base_ff;
      out_done_in  = out_done_ff;
      out_total_in = out_total_ff;
      if (cmd.emit_load) begin
         out_valid_in = 1'b1;
         out_send_in  = (qcnt_ff != '0);
         out_seq_in   = (qcnt_ff != '0) ? q_rd_ff.seq : '0;
         out_retx_in  = (qcnt_ff != '0) && q_rd_ff.retx;
         out_last_in  = emit_last;
         out_base_in  = FIELD_W'(base_ff);
         out_done_in  = !(base_w < total_eff);
         out_total_in = retx_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= TOTAL_RESET;
         wnd_ff       <= WINDOW_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         base_ff      <= '0;
         next_ff      <= '0;
         ptr_ff       <= '0;
         base_slot_ff <= '0;
         next_slot_ff <= '0;
         ptr_slot_ff  <= '0;
         acked_ff     <= '0;
         now_ff       <= '0;
         retx_ff      <= '0;
         qcnt_ff      <= '0;
         rd_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         wnd_ff       <= wnd_in;
         timeout_ff   <= timeout_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         ptr_ff       <= ptr_in;
         base_slot_ff <= base_slot_in;
         next_slot_ff <= next_slot_in;
         ptr_slot_ff  <= ptr_slot_in;
         acked_ff     <= acked_in;
         now_ff       <= now_in;
         retx_ff      <= retx_in;
         qcnt_ff      <= qcnt_in;
         rd_ff        <= rd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_send_ff  <= out_send_in;
      out_seq_ff   <= out_seq_in;
      out_retx_ff  <= out_retx_in;
      out_last_ff  <= out_last_in;
      out_base_ff  <= out_base_in;
      out_done_ff  <= out_done_in;
      out_total_ff <= out_total_in;
   end

   // send-time memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sent_at_mem[mem_waddr] <= now_ff;
      end
      if (cmd.scan_read) begin
         sent_rd_ff <= sent_at_mem[ptr_slot_ff];
      end
   end

   // result queue for one request's worth of transmissions
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[qcnt_ff[SLOT_W-1:0]] <= q_wdata;
      end
      if (cmd.emit_read) begin
         q_rd_ff <= queue_mem[rd_ff[SLOT_W-1:0]];
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_send_valid       = out_send_ff;
   assign rsp_send_sequence    = out_seq_ff;
   assign rsp_is_retransmit    = out_retx_ff;
   assign rsp_last             = out_last_ff;
   assign rsp_window_base      = out_base_ff;
   assign rsp_done_res         = out_done_ff;
   assign rsp_retransmit_total = out_total_ff;

   a_base_not_past_next: assert property (@(posedge clock) disable iff (reset)
      base_w <= next_w)
      else $error("window base passed next sequence");

   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      (next_w - base_w) <= WMAX_W)
      else $error("more packets outstanding than slots");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> (qcnt_ff <= CNT_MAX) && (rd_ff <= qcnt_ff || qcnt_ff == '0))
      else $error("result queue overrun");

endmodule

@@ sv/selective_repeat_sender_window.sv @@
// Selective repeat ARQ sender window. Each request word is a one-millisecond tick or an
// acknowledgement; the block marks the acknowledged slot, slides the base, issues new sequence
// numbers up to the window size, and retransmits outstanding packets older than timeout_ticks.
// Every request yields one or more response words (new sends first, then retransmissions from
// the base), the final one flagged by last; a request that sends nothing yields a single word
// with send_valid low. One request is processed at a time, in these steps: acceptance, the base
// slide over each acknowledged slot, the issuing of each new packet, the timeout scan of each
// outstanding packet (a read and then a check, as the send-time memory has a registered read
// port), and the drain, in which each response word is read from the result queue and then
// loaded into the output register once that is free. Once the transfer is complete issuing and
// the scan are skipped. The next request is taken while the last response word still waits in
// the output register.
module selective_repeat_sender_window import srsw_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF,
   parameter int SEQ_BITS   = SEQ_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   srsw_req_if.sink              req_chan,
   srsw_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   srsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   srsw_dp #(
      .WINDOW_MAX (WINDOW_MAX),
      .SEQ_BITS   (SEQ_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_opcode           (req_chan.opcode),
      .req_ack_number       (req_chan.ack_number),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_ready            (rsp_chan.ready),
      .rsp_valid            (rsp_chan.valid),
      .rsp_send_valid       (rsp_chan.send_valid),
      .rsp_send_sequence    (rsp_chan.send_sequence),
      .rsp_is_retransmit    (rsp_chan.is_retransmit),
      .rsp_last             (rsp_chan.last),
      .rsp_window_base      (rsp_chan.window_base),
      .rsp_done_res         (rsp_chan.done_res),
      .rsp_retransmit_total (rsp_chan.retransmit_total)
   );

endmodule

@@ test/srsw_send_checker.sv @@
// checker for the sender window: watches both channels and the register port, predicts and compares
module srsw_send_checker import srsw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   srsw_req_if                   req_mon,
   srsw_rsp_if                   rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    orders_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               send_valid;
      logic [FIELD_W-1:0] send_sequence;
      logic               is_retransmit;
      logic               last;
      logic [FIELD_W-1:0] window_base;
      logic               done_res;
      logic [FIELD_W-1:0] retransmit_total;
   } send_order_type;

   send_order_type orders_due[$];
   send_order_type head_order;
   send_order_type seen_order;

   logic [FIELD_W-1:0]   total_pkts;
   logic [WND_REG_W-1:0] wnd_reg;
   logic [FIELD_W-1:0]   tmo_reg;

   int                 win_base;
   int                 next_issue;
   logic               acked[WINDOW_MAX_DEF];
   logic [31:0]        sent_tick[WINDOW_MAX_DEF];
   logic [31:0]        tick_now;
   logic [FIELD_W-1:0] rtx_count;

   task automatic plan_transmissions(input logic op, input logic [FIELD_W-1:0] ack_num);
      int          lim;
      int          span;
      int          n;
      int          sq;
      int          s;
      int          k;
      int          a;
      logic [31:0] age;
      logic [FIELD_W-1:0] seqs[WINDOW_MAX_DEF];
      logic        rtx[WINDOW_MAX_DEF];
      send_order_type ord;
      lim  = total_pkts;
      span = wnd_reg;
      if (span < 1) span = 1;
      if (span > WINDOW_MAX_DEF) span = WINDOW_MAX_DEF;
      n = 0;
      a = ack_num;
      if (op == OP_TICK) begin
         tick_now = tick_now + 32'd1;
      end else if (a >= win_base && a < next_issue && a < lim) begin
         acked[a % WINDOW_MAX_DEF] = 1'b1;
      end
      while (win_base < lim && win_base < next_issue && acked[win_base % WINDOW_MAX_DEF]) begin
         acked[win_base % WINDOW_MAX_DEF] = 1'b0;
         win_base++;
      end
      if (win_base < lim) begin
         while (next_issue < lim && next_issue - win_base < span && n < WINDOW_MAX_DEF) begin
            s = next_issue % WINDOW_MAX_DEF;
            acked[s] = 1'b0;
            sent_tick[s] = tick_now;
            seqs[n] = FIELD_W'(next_issue);
            rtx[n] = 1'b0;
            n++;
            next_issue++;
         end
         for (sq = win_base; sq < next_issue && n < WINDOW_MAX_DEF; sq++) begin
            s = sq % WINDOW_MAX_DEF;
            age = tick_now - sent_tick[s];
            if (!acked[s] && age > 32'(tmo_reg)) begin
               sent_tick[s] = tick_now;
               if (rtx_count != 16'hFFFF) rtx_count++;
               seqs[n] = FIELD_W'(sq);
               rtx[n] = 1'b1;
               n++;
            end
         end
      end
      for (k = 0; k < ((n == 0) ? 1 : n); k++) begin
         ord.send_valid       = (n != 0);
         ord.send_sequence    = (n != 0) ? seqs[k] : '0;
         ord.is_retransmit    = (n != 0) ? rtx[k] : 1'b0;
         ord.last             = (k == ((n == 0) ? 0 : n - 1));
         ord.window_base      = FIELD_W'(win_base);
         ord.done_res         = (win_base >= lim);
         ord.retransmit_total = rtx_count;
         orders_due.push_back(ord);
      end
   endtask

   task automatic compare_field(input string name, input logic [FIELD_W-1:0] want,
                                input logic [FIELD_W-1:0] seen);
      if (seen !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         total_pkts = TOTAL_RESET;
         wnd_reg    = WINDOW_RESET;
         tmo_reg    = TIMEOUT_RESET;
         win_base   = 0;
         next_issue = 0;
         tick_now   = '0;
         rtx_count  = '0;
         for (int i = 0; i < WINDOW_MAX_DEF; i++) begin
            acked[i] = 1'b0;
            sent_tick[i] = '0;
         end
         orders_due.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TOTAL_PACKETS: total_pkts = csr_wdata[FIELD_W-1:0];
               CSR_WINDOW_SIZE:   wnd_reg    = csr_wdata[WND_REG_W-1:0];
               CSR_TIMEOUT_TICKS: tmo_reg    = csr_wdata[FIELD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen_order.send_valid       = rsp_mon.send_valid;
            seen_order.send_sequence    = rsp_mon.send_sequence;
            seen_order.is_retransmit    = rsp_mon.is_retransmit;
            seen_order.last             = rsp_mon.last;
            seen_order.window_base      = rsp_mon.window_base;
            seen_order.done_res         = rsp_mon.done_res;
            seen_order.retransmit_total = rsp_mon.retransmit_total;
            if (orders_due.size() == 0) begin
               $display("%0t: unexpected word, expected none got %0h", $time, seen_order);
               mismatches++;
            end else begin
               head_order = orders_due.pop_front();
               compare_field("send_valid", FIELD_W'(head_order.send_valid),
                             FIELD_W'(seen_order.send_valid));
               compare_field("send_sequence", head_order.send_sequence,
                             seen_order.send_sequence);
               compare_field("is_retransmit", FIELD_W'(head_order.is_retransmit),
                             FIELD_W'(seen_order.is_retransmit));
               compare_field("last", FIELD_W'(head_order.last), FIELD_W'(seen_order.last));
               compare_field("window_base", head_order.window_base, seen_order.window_base);
               compare_field("done_res", FIELD_W'(head_order.done_res),
                             FIELD_W'(seen_order.done_res));
               compare_field("retransmit_total", head_order.retransmit_total,
                             seen_order.retransmit_total);
            end
         end
         if (req_mon.valid && req_mon.ready)
            plan_transmissions(req_mon.opcode, req_mon.ack_number);
      end
      orders_waiting = orders_due.size();
   end

endmodule

@@ test/tb_selective_repeat_sender_window.sv @@
// testbench top for the sender window: clock, reset, stimulus, idling and verdict
module tb_selective_repeat_sender_window;
   timeunit 1ns;
   timeprecision 1ps;
   import srsw_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int orders_waiting;
   int req_idle_pct;
   int rsp_idle_pct;
   int seen_base;
   int seen_next;
   int stall_cycles;

   srsw_req_if req_chan();
   srsw_rsp_if rsp_chan();

   selective_repeat_sender_window dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   srsw_send_checker send_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .orders_waiting (orders_waiting)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // window tracking for ack shaping, and the watchdog
   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready) begin
         seen_base = rsp_chan.window_base;
         if (rsp_chan.send_valid && !rsp_chan.is_retransmit)
            seen_next = rsp_chan.send_sequence + 1;
      end
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic push_word(input logic op, input logic [FIELD_W-1:0] num);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= op;
      req_chan.ack_number <= num;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_random_word();
      int pick;
      int lo;
      int hi;
      pick = $urandom_range(0, 99);
      lo = seen_base;
      hi = (seen_next > lo) ? seen_next - 1 : lo;
      if (pick < 35)
         push_word(OP_TICK, FIELD_W'($urandom));
      else if (pick < 85)
         push_word(OP_ACK, FIELD_W'($urandom_range(hi, lo)));
      else if (pick < 93)
         push_word(OP_ACK, FIELD_W'($urandom));
      else
         push_word(OP_ACK, $urandom_range(0, 1) ? FIELD_W'(lo - 1) : FIELD_W'(seen_next));
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (orders_waiting != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] tot, input logic [CSR_DATA_W-1:0] wnd,
                               input logic [CSR_DATA_W-1:0] tmo);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_TOTAL_PACKETS;
      csr_wdata <= tot;
      @(negedge clock);
      csr_index <= CSR_WINDOW_SIZE;
      csr_wdata <= wnd;
      @(negedge clock);
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_wdata <= tmo;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] tot;
      clock               = 1'b0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_TOTAL_PACKETS;
      csr_wdata           = '0;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = OP_TICK;
      req_chan.ack_number = '0;
      rsp_chan.ready      = 1'b0;
      req_idle_pct        = 18;
      rsp_idle_pct        = 70;
      seen_base           = 0;
      seen_next           = 0;
      stall_cycles        = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: out of order, stale and never-sent acks
      push_word(OP_TICK, 16'h0000);
      push_word(OP_ACK, 16'hFFFF);
      push_word(OP_ACK, 16'd2);
      push_word(OP_ACK, 16'd0);
      push_word(OP_ACK, 16'd1);
      push_word(OP_ACK, 16'd0);
      push_word(OP_ACK, 16'd7);
      // timeout of one tick
      program_regs(16'd100, 16'd4, 16'd1);
      repeat (3) push_word(OP_TICK, 16'hFFFF);
      // total lowered mid transfer, then complete
      program_regs(16'd5, 16'd4, 16'd1);
      push_word(OP_ACK, 16'd3);
      push_word(OP_TICK, 16'd0);
      push_word(OP_ACK, 16'd4);
      push_word(OP_TICK, 16'd0);
      // window zero and largest total
      program_regs(16'hFFFF, 16'd0, 16'd1);
      push_word(OP_TICK, 16'd0);
      push_word(OP_ACK, 16'd5);
      push_word(OP_ACK, 16'd6);
      // window above the slot count, longest timeout
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_word(OP_TICK, 16'd0);
      push_word(OP_TICK, 16'd0);
      program_regs(16'hFFFF, 16'hFFFF, 16'd0);
      push_word(OP_TICK, 16'd0);
      // empty transfer
      program_regs(16'd0, 16'd32, 16'd0);
      push_word(OP_TICK, 16'd0);
      push_word(OP_ACK, 16'd10);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               req_idle_pct = 18;
               rsp_idle_pct = 70;
            end
            1: begin
               req_idle_pct = 70;
               rsp_idle_pct = 18;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         settle();
         if (phase == 1 || phase == 4)
            tot = CSR_DATA_W'(seen_next + $urandom_range(5, 30));
         else if (phase == 3)
            tot = CSR_DATA_W'(seen_base);
         else
            tot = 16'hFFFF;
         program_regs(tot, CSR_DATA_W'($urandom_range(1, 32)), CSR_DATA_W'($urandom_range(1, 24)));
         repeat (58) push_random_word();
      end

      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (orders_waiting != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatches == 0 && orders_waiting == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
